// ===== hdl/pds_pkg.sv =====
// shared types, codes and constants of the position deadband scaler
// no dependencies; imported by pot_deadband_scaler
`default_nettype none

package pds_pkg;

   // effective source type codes
   localparam logic [1:0] TYPE_OFF    = 2'd0;
   localparam logic [1:0] TYPE_NORMAL = 2'd1;
   localparam logic [1:0] TYPE_CENTRE = 2'd2;
   localparam logic [1:0] MODE_AUTO   = 2'd3;

   // register indexes on the csr port (byte address = 4 * index)
   localparam logic [2:0] REG_INPUT_MODE = 3'd0;
   localparam logic [2:0] REG_CAL_MIN    = 3'd1;
   localparam logic [2:0] REG_CAL_MID    = 3'd2;
   localparam logic [2:0] REG_CAL_MAX    = 3'd3;
   localparam logic [2:0] REG_DEAD_BAND  = 3'd4;
   localparam logic [2:0] REG_OUT_LOW    = 3'd5;
   localparam logic [2:0] REG_OUT_HIGH   = 3'd6;

   localparam int CSR_AW = 5;

   // quotient bits the divider resolves; larger quotients saturate
   localparam int DIV_BITS = 16;
   localparam int REM_W    = 34;
   localparam int DEN_W    = 18;

   // pipeline: front stages, then one stage per quotient bit, then the output stage
   localparam int FRONT_STG = 5;
   localparam int NSTG      = FRONT_STG + DIV_BITS + 1;

   // reciprocal of 200 for 16-bit magnitudes: ceil(2^23 / 200)
   localparam int unsigned REC200    = 41944;
   localparam int          REC_SHIFT = 23;

   // clamp bounds, zero flag and type that ride along with the arithmetic
   typedef struct packed {
      logic signed [15:0] lo;
      logic signed [15:0] hi;
      logic               zero;
      logic [1:0]         typ;
   } side_type;

   // truncated-toward-zero division by 200 of a signed 16-bit value
   function automatic logic signed [8:0] div200(input logic signed [15:0] v);
      logic [16:0] mag;
      logic [32:0] prod;
      logic [8:0]  q;
      mag  = v[15] ? 17'(-$signed({v[15], v})) : {1'b0, v};
      prod = 33'(mag) * 33'(REC200);
      q    = prod[REC_SHIFT+8:REC_SHIFT];
      return v[15] ? -$signed(q) : $signed(q);
   endfunction

endpackage

`default_nettype wire

// ===== hdl/pot_deadband_scaler.sv =====
// top level of the position deadband scaler: csr registers, classifier, mapping pipeline
// depends on pds_pkg
`default_nettype none

// Turns one signed 16-bit raw position sample into a clamped motor command and reports the
// source type it used (0 off, 1 normal pot, 2 centre-rest pot). The type comes from
// input_mode, or in auto mode from the calibration values compared after truncated division
// by 200. A normal pot maps cal_min..cal_max onto 0..out_high; a centre-rest pot gives 0
// strictly inside mid +/- dead_band and maps each side onto 0..out_high or 0..out_low. All
// quotients truncate toward zero, a zero input span gives 0, and every command is clamped.
// The datapath is a 22-stage pipeline: classification, operand select, one multiply, sign
// handling, an overflow check, one restoring-division stage per quotient bit (16) and the
// clamp/output register. A new request may enter every cycle while nothing stalls. Each
// stage holds its item until the next stage frees up, so a stalled result only stops the
// stages behind it once they fill. Registers sit at byte addresses 4*index on the
// APB-style port and should be written only while no request is in flight.
module pot_deadband_scaler (
   input  wire                      clock,
   input  wire                      reset,
   // request channel
   input  wire                      req_valid,
   output logic                     req_stall,
   input  wire  signed [15:0]       req_raw_position,
   // result channel
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output logic signed [15:0]       rsp_command,
   output logic [1:0]               rsp_pot_type,
   // csr port
   input  wire                      psel,
   input  wire                      penable,
   input  wire                      pwrite,
   input  wire  [pds_pkg::CSR_AW-1:0] paddr,
   input  wire  [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);
   import pds_pkg::*;

   // ---------------------------------------------------------------- csr registers
   logic [1:0]         input_mode_ff;
   logic signed [15:0] cal_min_ff;
   logic signed [15:0] cal_mid_ff;
   logic signed [15:0] cal_max_ff;
   logic [14:0]        dead_band_ff;
   logic signed [15:0] out_low_ff;
   logic [14:0]        out_high_ff;

   logic       csr_wr;
   logic [2:0] csr_idx;

   assign pready  = 1'b1;
   assign csr_idx = paddr[CSR_AW-1:2];
   assign csr_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         input_mode_ff <= MODE_AUTO;
         cal_min_ff    <= '0;
         cal_mid_ff    <= '0;
         cal_max_ff    <= '0;
         dead_band_ff  <= '0;
         out_low_ff    <= -16'sd1000;
         out_high_ff   <= 15'd1000;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_INPUT_MODE: input_mode_ff <= pwdata[1:0];
            REG_CAL_MIN:    cal_min_ff    <= pwdata[15:0];
            REG_CAL_MID:    cal_mid_ff    <= pwdata[15:0];
            REG_CAL_MAX:    cal_max_ff    <= pwdata[15:0];
            REG_DEAD_BAND:  dead_band_ff  <= pwdata[14:0];
            REG_OUT_LOW:    out_low_ff    <= pwdata[15:0];
            REG_OUT_HIGH:   out_high_ff   <= pwdata[14:0];
            default:        ; // unmapped address, write dropped
         endcase
      end
   end

   // read back, signed registers sign extended
   always_comb begin
      case (csr_idx)
         REG_INPUT_MODE: prdata = {30'b0, input_mode_ff};
         REG_CAL_MIN:    prdata = 32'(cal_min_ff);
         REG_CAL_MID:    prdata = 32'(cal_mid_ff);
         REG_CAL_MAX:    prdata = 32'(cal_max_ff);
         REG_DEAD_BAND:  prdata = {17'b0, dead_band_ff};
         REG_OUT_LOW:    prdata = 32'(out_low_ff);
         REG_OUT_HIGH:   prdata = {17'b0, out_high_ff};
         default:        prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- pipeline flow control
   // a stage loads when it is empty or its item moves on in the same cycle
   logic [NSTG-1:0] v_ff;
   logic [NSTG-1:0] go;

   always_comb begin
      go[NSTG-1] = !v_ff[NSTG-1] || !rsp_stall;
      for (int k = NSTG - 2; k >= 0; k--) begin
         go[k] = !v_ff[k] || go[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (go[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int k = 1; k < NSTG; k++) begin
            if (go[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   assign req_stall = !go[0];

   // ---------------------------------------------------------------- stage 0: classify
   // auto mode compares the calibration quotients by 200 and checks that min and mid do not exceed max
   logic signed [8:0] q_min, q_mid, q_max;
   logic [1:0]        auto_typ;
   logic [1:0]        s0_typ_in;
   logic [1:0]        s0_typ_ff;
   logic signed [15:0] s0_raw_ff;

   always_comb begin
      q_min = div200(cal_min_ff);
      q_mid = div200(cal_mid_ff);
      q_max = div200(cal_max_ff);
      if (q_min == q_max || q_mid == q_max || cal_min_ff > cal_max_ff
          || cal_mid_ff > cal_max_ff) begin
         auto_typ = TYPE_OFF;
      end else if (q_min == q_mid) begin
         auto_typ = TYPE_NORMAL;
      end else begin
         auto_typ = TYPE_CENTRE;
      end
      s0_typ_in = (input_mode_ff == MODE_AUTO) ? auto_typ : input_mode_ff;
   end

   always_ff @(posedge clock) begin
      if (go[0]) begin
         s0_raw_ff <= req_raw_position;
         s0_typ_ff <= s0_typ_in;
      end
   end

   // ---------------------------------------------------------------- stage 1: operand select
   logic signed [16:0] raw17, mid17, db17, mid_hi, mid_lo;
   logic signed [16:0] op_a, op_b, op_scale;
   logic               in_band, above;
   side_type           s1_side_in, s1_side_ff;
   logic signed [17:0] s1_x_in, s1_x_ff;
   logic signed [17:0] s1_span_in, s1_span_ff;
   logic signed [16:0] s1_scale_ff;

   always_comb begin
      raw17   = 17'(s0_raw_ff);
      mid17   = 17'(cal_mid_ff);
      db17    = $signed({2'b0, dead_band_ff});
      mid_hi  = mid17 + db17;
      mid_lo  = mid17 - db17;
      in_band = (raw17 > mid_lo) && (raw17 < mid_hi);
      above   = s0_raw_ff > cal_mid_ff;

      // normal-pot operands by default
      op_a             = 17'(cal_min_ff);
      op_b             = 17'(cal_max_ff);
      op_scale         = $signed({2'b0, out_high_ff});
      s1_side_in.lo    = '0;
      s1_side_in.hi    = $signed({1'b0, out_high_ff});
      s1_side_in.zero  = 1'b0;
      s1_side_in.typ   = s0_typ_ff;

      case (s0_typ_ff)
         TYPE_NORMAL: ;
         TYPE_CENTRE: begin
            s1_side_in.zero = in_band;
            if (above) begin
               op_a = mid_hi;
               op_b = 17'(cal_max_ff);
            end else begin
               // negative side maps toward cal_min onto 0..out_low
               op_a          = mid_lo;
               op_b          = 17'(cal_min_ff);
               op_scale      = 17'(out_low_ff);
               s1_side_in.lo = out_low_ff;
               s1_side_in.hi = '0;
            end
         end
         default: s1_side_in.zero = 1'b1;
      endcase

      s1_x_in    = 18'(raw17) - 18'(op_a);
      s1_span_in = 18'(op_b) - 18'(op_a);
   end

   always_ff @(posedge clock) begin
      if (go[1]) begin
         s1_x_ff     <= s1_x_in;
         s1_span_ff  <= s1_span_in;
         s1_scale_ff <= op_scale;
         s1_side_ff  <= s1_side_in;
      end
   end

   // ---------------------------------------------------------------- stage 2: multiply
   logic signed [34:0] s2_prod_ff;
   logic signed [17:0] s2_span_ff;
   side_type           s2_side_ff;

   always_ff @(posedge clock) begin
      if (go[2]) begin
         // zero span becomes 0 / 1, so the zero result still goes through the clamp
         if (s1_span_ff == '0) begin
            s2_prod_ff <= '0;
            s2_span_ff <= 18'sd1;
         end else begin
            s2_prod_ff <= 35'(s1_x_ff) * 35'(s1_scale_ff);
            s2_span_ff <= s1_span_ff;
         end
         s2_side_ff <= s1_side_ff;
      end
   end

   // ---------------------------------------------------------------- stage 3: magnitudes
   logic [REM_W-1:0] s3_num_in, s3_num_ff;
   logic [DEN_W-1:0] s3_den_in, s3_den_ff;
   logic             s3_neg_ff;
   side_type         s3_side_ff;

   always_comb begin
      s3_num_in = s2_prod_ff[34] ? REM_W'(-s2_prod_ff) : REM_W'(s2_prod_ff);
      s3_den_in = s2_span_ff[17] ? DEN_W'(-s2_span_ff) : DEN_W'(s2_span_ff);
   end

   always_ff @(posedge clock) begin
      if (go[3]) begin
         s3_num_ff  <= s3_num_in;
         s3_den_ff  <= s3_den_in;
         s3_neg_ff  <= s2_prod_ff[34] ^ s2_span_ff[17];
         s3_side_ff <= s2_side_ff;
      end
   end

   // ---------------------------------------------------------------- stage 4: overflow check
   // a quotient of 2^16 or more is beyond every clamp bound
   logic [REM_W-1:0] s4_num_ff;
   logic [DEN_W-1:0] s4_den_ff;
   logic             s4_neg_ff;
   logic             s4_sat_ff;
   side_type         s4_side_ff;

   always_ff @(posedge clock) begin
      if (go[4]) begin
         s4_num_ff  <= s3_num_ff;
         s4_den_ff  <= s3_den_ff;
         s4_neg_ff  <= s3_neg_ff;
         s4_sat_ff  <= s3_num_ff[REM_W-1:DIV_BITS] >= s3_den_ff;
         s4_side_ff <= s3_side_ff;
      end
   end

   // ---------------------------------------------------------------- restoring divider
   // one quotient bit per stage, most significant first
   logic [REM_W-1:0]    dv_rem_ff  [DIV_BITS];
   logic [DEN_W-1:0]    dv_den_ff  [DIV_BITS];
   logic [DIV_BITS-1:0] dv_quo_ff  [DIV_BITS];
   logic                dv_neg_ff  [DIV_BITS];
   logic                dv_sat_ff  [DIV_BITS];
   side_type            dv_side_ff [DIV_BITS];

   for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
      localparam int BITPOS = DIV_BITS - 1 - j;
      logic [REM_W-1:0]    src_rem;
      logic [DEN_W-1:0]    src_den;
      logic [DIV_BITS-1:0] src_quo;
      logic                src_neg;
      logic                src_sat;
      side_type            src_side;
      logic [REM_W-1:0]    trial;
      logic                take;
      logic [REM_W-1:0]    rem_in;
      logic [DIV_BITS-1:0] quo_in;

      if (j == 0) begin : g_first
         assign src_rem  = s4_num_ff;
         assign src_den  = s4_den_ff;
         assign src_quo  = '0;
         assign src_neg  = s4_neg_ff;
         assign src_sat  = s4_sat_ff;
         assign src_side = s4_side_ff;
      end else begin : g_next
         assign src_rem  = dv_rem_ff[j-1];
         assign src_den  = dv_den_ff[j-1];
         assign src_quo  = dv_quo_ff[j-1];
         assign src_neg  = dv_neg_ff[j-1];
         assign src_sat  = dv_sat_ff[j-1];
         assign src_side = dv_side_ff[j-1];
      end

      always_comb begin
         trial  = REM_W'(src_den) << BITPOS;
         take   = src_rem >= trial;
         rem_in = take ? (src_rem - trial) : src_rem;
         quo_in = src_quo;
         quo_in[BITPOS] = take;
      end

      always_ff @(posedge clock) begin
         if (go[FRONT_STG+j]) begin
            dv_rem_ff[j]  <= rem_in;
            dv_den_ff[j]  <= src_den;
            dv_quo_ff[j]  <= quo_in;
            dv_neg_ff[j]  <= src_neg;
            dv_sat_ff[j]  <= src_sat;
            dv_side_ff[j] <= src_side;
         end
      end
   end

   // ---------------------------------------------------------------- output stage: sign and clamp
   logic [DIV_BITS-1:0] q_mag;
   logic signed [17:0]  q_val, hi18, lo18;
   logic signed [15:0]  cmd_in;
   logic signed [15:0]  out_cmd_ff;
   logic [1:0]          out_typ_ff;
   side_type            fin_side;

   always_comb begin
      fin_side = dv_side_ff[DIV_BITS-1];
      q_mag    = dv_sat_ff[DIV_BITS-1] ? '1 : dv_quo_ff[DIV_BITS-1];
      q_val    = dv_neg_ff[DIV_BITS-1] ? -$signed({2'b0, q_mag}) : $signed({2'b0, q_mag});
      hi18     = 18'(fin_side.hi);
      lo18     = 18'(fin_side.lo);
      // upper bound wins, as with an inverted pair of bounds
      if (fin_side.zero) begin
         cmd_in = '0;
      end else if (q_val > hi18) begin
         cmd_in = fin_side.hi;
      end else if (q_val < lo18) begin
         cmd_in = fin_side.lo;
      end else begin
         cmd_in = q_val[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (go[NSTG-1]) begin
         out_cmd_ff <= cmd_in;
         out_typ_ff <= fin_side.typ;
      end
   end

   assign rsp_valid    = v_ff[NSTG-1];
   assign rsp_command  = out_cmd_ff;
   assign rsp_pot_type = out_typ_ff;

   // ---------------------------------------------------------------- assertions
   // an accepted request always lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v_ff[0])
      else $error("accepted request missing from first stage");

   // with the output register empty nothing upstream may hold back a request
   a_empty_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled while output stage empty");

   // a disabled source always commands zero
   a_off_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pot_type == TYPE_OFF) |-> (rsp_command == '0))
      else $error("nonzero command for disabled source");

endmodule

`default_nettype wire

// ===== tb/pot_deadband_scaler_test.sv =====
// self-checking testbench for pot_deadband_scaler: directed probe table, then random phases
// depends on pds_pkg and pot_deadband_scaler; predicts every command and type locally
`timescale 1ns / 1ps

module pot_deadband_scaler_test;
   import pds_pkg::*;

   localparam int RANDOM_ITEMS  = 1800;
   localparam int SETTLE_CYCLES = 30;       // pipeline is 22 deep, leave some slack
   localparam int RUN_LIMIT_NS  = 3000000;  // far beyond the slowest pass

   // spare register slot past the last register, writes there must be dropped
   localparam logic [2:0] REG_SPARE = 3'd7;

   // register image kept by the testbench
   typedef struct packed {
      logic [1:0]         mode;
      logic signed [15:0] cal_min;
      logic signed [15:0] cal_mid;
      logic signed [15:0] cal_max;
      logic [14:0]        dead_band;
      logic signed [15:0] out_low;
      logic [14:0]        out_high;
   } scaler_cfg_type;

   typedef struct packed {
      logic signed [15:0] command;
      logic [1:0]         pot_type;
   } scaler_result_type;

   // one directed probe: which register setup, the raw sample, optional typed-in answer
   typedef struct {
      int                 setup;
      logic signed [15:0] raw;
      bit                 known;
      scaler_result_type  typed;
   } probe_row_type;

   // receiver stall patterns
   typedef enum logic [1:0] {FLOW_FREE, FLOW_RANDOM, FLOW_PERIODIC, FLOW_HEAVY} flow_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_raw_position = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_command;
   logic [1:0]         rsp_pot_type;

   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;

   scaler_cfg_type    cfg;                  // current register contents as seen by the predictor
   scaler_cfg_type    setups[10];           // register setups used by the probe table
   probe_row_type     probe_rows[$];
   scaler_result_type pending_results[$];   // commands still owed by the block, oldest first
   int                fail_count = 0;
   int                burst_left = 0;

   flow_type flow_mode = FLOW_FREE;
   int       flow_left = 0;

   pot_deadband_scaler dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_raw_position (req_raw_position),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_command      (rsp_command),
      .rsp_pot_type     (rsp_pot_type),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   // linear map with truncating division, zero span gives 0
   function automatic longint span_map(longint x, longint a, longint b, longint c, longint d);
      if (b == a) return 0;
      return ((x - a) * (d - c)) / (b - a) + c;
   endfunction

   // upper bound wins first, so a reversed pair still behaves like the block
   function automatic longint bound(longint x, longint lo, longint hi);
      if (x > hi) return hi;
      if (x < lo) return lo;
      return x;
   endfunction

   function automatic scaler_result_type predict_result(scaler_cfg_type c,
                                                        logic signed [15:0] raw);
      longint x, mn, mid, mx, db, lo, hi, cmd;
      int qmin, qmid, qmax;
      logic [1:0] typ;
      scaler_result_type r;
      x   = longint'(raw);
      mn  = longint'($signed(c.cal_min));
      mid = longint'($signed(c.cal_mid));
      mx  = longint'($signed(c.cal_max));
      db  = longint'(c.dead_band);
      lo  = longint'($signed(c.out_low));
      hi  = longint'(c.out_high);
      typ = c.mode;
      // auto mode: classify on calibration quotients by 200, truncated toward zero
      if (c.mode == MODE_AUTO) begin
         qmin = int'(mn) / 200;
         qmid = int'(mid) / 200;
         qmax = int'(mx) / 200;
         if (qmin == qmax || qmid == qmax || mn > mx || mid > mx)
            typ = TYPE_OFF;
         else
            typ = (qmin == qmid) ? TYPE_NORMAL : TYPE_CENTRE;
      end
      cmd = 0;
      if (typ == TYPE_NORMAL) begin
         cmd = bound(span_map(x, mn, mx, 0, hi), 0, hi);
      end else if (typ == TYPE_CENTRE) begin
         // open band around mid, then each side mapped on its own
         if (x > mid - db && x < mid + db)
            cmd = 0;
         else if (x > mid)
            cmd = bound(span_map(x, mid + db, mx, 0, hi), 0, hi);
         else
            cmd = bound(span_map(x, mid - db, mn, 0, lo), lo, 0);
      end
      r.command  = 16'(cmd);
      r.pot_type = typ;
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic scaler_cfg_type make_cfg(logic [1:0] mode, int mn, int md, int mx,
                                               int db, int lo, int hi);
      scaler_cfg_type s;
      s.mode      = mode;
      s.cal_min   = 16'(mn);
      s.cal_mid   = 16'(md);
      s.cal_max   = 16'(mx);
      s.dead_band = 15'(db);
      s.out_low   = 16'(lo);
      s.out_high  = 15'(hi);
      return s;
   endfunction

   function automatic void add_probe(int setup, int raw, bit known, int cmd, logic [1:0] typ);
      probe_row_type p;
      p.setup            = setup;
      p.raw              = 16'(raw);
      p.known            = known;
      p.typed.command    = 16'(cmd);
      p.typed.pot_type   = typ;
      probe_rows.push_back(p);
   endfunction

   function automatic int sat16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // random register setup, mostly sane calibrations with the odd extreme or wild value
   function automatic scaler_cfg_type make_setup();
      int mode_pick, mid, mn, mx, db, lo, hi;
      logic [1:0] mode;
      mode_pick = $urandom_range(0, 9);
      if (mode_pick == 0)      mode = TYPE_OFF;
      else if (mode_pick < 4)  mode = TYPE_NORMAL;
      else if (mode_pick < 7)  mode = TYPE_CENTRE;
      else                     mode = MODE_AUTO;
      mid = int'($signed(16'($urandom())));
      mn  = sat16(mid - int'($urandom_range(0, 20000)));
      mx  = sat16(mid + int'($urandom_range(0, 20000)));
      case ($urandom_range(0, 9))
         0: mn = int'($signed(16'($urandom())));
         1: mx = int'($signed(16'($urandom())));
         2: begin
            mn = -32768;
            mx = 32767;
         end
         3: mid = int'($signed(16'($urandom())));
         default: ;
      endcase
      case ($urandom_range(0, 7))
         0: db = 0;
         1: db = 32767;
         2: db = int'($urandom_range(0, 32767));
         default: db = int'($urandom_range(0, 2000));
      endcase
      case ($urandom_range(0, 9))
         0: lo = -32768;
         1: lo = 0;
         2: lo = int'($urandom_range(1, 32767));   // positive floor on the negative side
         default: lo = -int'($urandom_range(1, 32767));
      endcase
      case ($urandom_range(0, 7))
         0: hi = 0;
         1: hi = 32767;
         default: hi = int'($urandom_range(1, 32767));
      endcase
      return make_cfg(mode, mn, mid, mx, db, lo, hi);
   endfunction

   // raw samples: random, inside the calibrated span, or aimed at the calibration points, the band edges and the rails
   function automatic logic signed [15:0] pick_position(scaler_cfg_type c);
      int span;
      case ($urandom_range(0, 5))
         0: return 16'($urandom());
         1: return 16'(int'($signed(c.cal_min)) + int'($urandom_range(0, 64)) - 32);
         2: return 16'(int'($signed(c.cal_mid)) + (($urandom_range(0, 1) == 1) ? 1 : -1)
                       * (int'(c.dead_band) + int'($urandom_range(0, 6)) - 3));
         3: return 16'(int'($signed(c.cal_max)) + int'($urandom_range(0, 64)) - 32);
         4: begin
            span = int'($signed(c.cal_max)) - int'($signed(c.cal_min));
            if (span <= 0) span = 65535;
            return 16'(int'($signed(c.cal_min)) + int'($urandom_range(0, span)));
         end
         default: begin
            case ($urandom_range(0, 3))
               0: return 16'h8000;
               1: return 16'h7fff;
               2: return 16'h0000;
               default: return 16'hffff;
            endcase
         end
      endcase
   endfunction

   // ---------------------------------------------------------------- bus tasks

   // apb write, setup then access phase, then the bus goes idle; the image follows the masking
   task automatic reg_write(input logic [2:0] idx, input logic [31:0] wdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_INPUT_MODE: cfg.mode      = wdata[1:0];
         REG_CAL_MIN:    cfg.cal_min   = wdata[15:0];
         REG_CAL_MID:    cfg.cal_mid   = wdata[15:0];
         REG_CAL_MAX:    cfg.cal_max   = wdata[15:0];
         REG_DEAD_BAND:  cfg.dead_band = wdata[14:0];
         REG_OUT_LOW:    cfg.out_low   = wdata[15:0];
         REG_OUT_HIGH:   cfg.out_high  = wdata[14:0];
         default: ;   // unmapped slot, nothing changes
      endcase
   endtask

   // hold requests until every owed command is back and the pipeline has emptied
   task automatic settle();
      req_valid        <= 1'b0;
      req_raw_position <= 16'($urandom());
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   // load a full setup, junk in the unused upper data bits
   task automatic apply_setup(input scaler_cfg_type s);
      logic [31:0] noise;
      settle();
      noise = $urandom(); reg_write(REG_INPUT_MODE, {noise[31:2], s.mode});
      noise = $urandom(); reg_write(REG_CAL_MIN, {noise[31:16], s.cal_min});
      noise = $urandom(); reg_write(REG_CAL_MID, {noise[31:16], s.cal_mid});
      noise = $urandom(); reg_write(REG_CAL_MAX, {noise[31:16], s.cal_max});
      noise = $urandom(); reg_write(REG_DEAD_BAND, {noise[31:15], s.dead_band});
      noise = $urandom(); reg_write(REG_OUT_LOW, {noise[31:16], s.out_low});
      noise = $urandom(); reg_write(REG_OUT_HIGH, {noise[31:15], s.out_high});
   endtask

   // one request; sender runs in bursts, a gap only opens when a burst runs out
   task automatic send_request(input logic signed [15:0] raw, input bit known,
                               input scaler_result_type typed);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
         if (gap != 0) begin
            req_valid        <= 1'b0;
            req_raw_position <= 16'($urandom());
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 48);
      end
      req_valid        <= 1'b1;
      req_raw_position <= raw;
      // req_stall read here is its value just before this edge
      do @(posedge clock); while (req_stall);
      pending_results.push_back(known ? typed : predict_result(cfg, raw));
      burst_left--;
   endtask

   // ---------------------------------------------------------------- receiver

   // stall pattern switches between free flow, random, periodic and heavy back-pressure
   always @(posedge clock) begin
      if (flow_left == 0) begin
         flow_mode <= flow_type'($urandom_range(0, 3));
         flow_left <= $urandom_range(16, 160);
      end else begin
         flow_left <= flow_left - 1;
      end
      case (flow_mode)
         FLOW_FREE:     rsp_stall <= 1'b0;
         FLOW_RANDOM:   rsp_stall <= ($urandom_range(0, 2) == 0);
         FLOW_PERIODIC: rsp_stall <= (flow_left % 4 == 0);
         default:       rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // each accepted result against the oldest owed command
   always @(posedge clock) begin : check_results
      scaler_result_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result with no request outstanding: command %0d pot_type %0d",
                   rsp_command, rsp_pot_type);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_command !== want.command) begin
               $error("command: expected %0d, got %0d", want.command, rsp_command);
               fail_count++;
            end
            if (rsp_pot_type !== want.pot_type) begin
               $error("pot_type: expected %0d, got %0d", want.pot_type, rsp_pot_type);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- main sequence

   initial begin : stimulus
      int active_setup;
      int sent;
      int phase_len;

      // setup 0 is the reset state and is never written
      setups[0] = make_cfg(MODE_AUTO, 0, 0, 0, 0, -1000, 1000);
      setups[1] = make_cfg(TYPE_NORMAL, -1000, 0, 1000, 0, -1000, 1000);
      setups[2] = make_cfg(TYPE_NORMAL, 500, 0, 500, 0, -1000, 1000);        // zero span
      setups[3] = make_cfg(TYPE_CENTRE, -32768, 0, 32767, 100, -32768, 32767);
      setups[4] = make_cfg(TYPE_CENTRE, -1000, 0, 1000, 50, 500, 0);         // positive floor
      setups[5] = make_cfg(TYPE_OFF, -32768, 32767, 0, 32767, -32768, 32767);
      setups[6] = make_cfg(MODE_AUTO, -10000, 0, 10000, 0, -1000, 1000);     // auto, centre
      setups[7] = make_cfg(MODE_AUTO, -199, 199, 1000, 10, -500, 700);       // auto, normal
      setups[8] = make_cfg(MODE_AUTO, 5000, 0, 1000, 0, -1000, 1000);        // min above max
      setups[9] = make_cfg(TYPE_CENTRE, -32768, 0, 32767, 32767, -32768, 32767);

      // after reset: auto mode, flat calibration, so off
      add_probe(0, -32768, 1, 0, TYPE_OFF);
      add_probe(0, 32767, 1, 0, TYPE_OFF);
      // normal pot, end points, rails and centre
      add_probe(1, -1000, 1, 0, TYPE_NORMAL);
      add_probe(1, 1000, 1, 1000, TYPE_NORMAL);
      add_probe(1, 32767, 1, 1000, TYPE_NORMAL);
      add_probe(1, -32768, 1, 0, TYPE_NORMAL);
      add_probe(1, 0, 1, 500, TYPE_NORMAL);
      add_probe(2, 12345, 1, 0, TYPE_NORMAL);
      // centre-rest, full-scale sides and the band
      add_probe(3, 0, 1, 0, TYPE_CENTRE);
      add_probe(3, 99, 1, 0, TYPE_CENTRE);
      add_probe(3, 32767, 1, 32767, TYPE_CENTRE);
      add_probe(3, -32768, 1, -32768, TYPE_CENTRE);
      add_probe(3, -5000, 0, 0, TYPE_OFF);
      add_probe(3, 5000, 0, 0, TYPE_OFF);
      add_probe(4, -500, 0, 0, TYPE_OFF);
      add_probe(4, -2000, 0, 0, TYPE_OFF);
      add_probe(4, 2000, 0, 0, TYPE_OFF);
      // disabled
      add_probe(5, -32768, 1, 0, TYPE_OFF);
      add_probe(5, 1, 1, 0, TYPE_OFF);
      // auto classification cases
      add_probe(6, 0, 0, 0, TYPE_OFF);
      add_probe(6, -10000, 0, 0, TYPE_OFF);
      add_probe(7, 500, 0, 0, TYPE_OFF);
      add_probe(8, 300, 1, 0, TYPE_OFF);
      // widest dead band, band edges reach +/-32767
      add_probe(9, 32767, 0, 0, TYPE_OFF);
      add_probe(9, -32768, 0, 0, TYPE_OFF);

      cfg          = setups[0];
      active_setup = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed probes
      foreach (probe_rows[i]) begin
         if (probe_rows[i].setup != active_setup) begin
            apply_setup(setups[probe_rows[i].setup]);
            active_setup = probe_rows[i].setup;
         end
         send_request(probe_rows[i].raw, probe_rows[i].known, probe_rows[i].typed);
      end

      // write to the unmapped slot must leave everything as it was
      settle();
      reg_write(REG_SPARE, $urandom());
      add_probe(0, 0, 0, 0, TYPE_OFF);
      send_request(16'sd123, 1'b0, '0);
      send_request(-16'sd4567, 1'b0, '0);

      // random phases, each with its own setup; every change waits for the pipe to empty
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         apply_setup(make_setup());
         phase_len = $urandom_range(20, 100);
         repeat (phase_len) begin
            send_request(pick_position(cfg), 1'b0, '0);
            sent++;
         end
      end

      // drain and report
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("pot_deadband_scaler: match");
      else
         $display("pot_deadband_scaler: mismatch");
      $finish;
   end

   // watchdog
   initial begin
      #(RUN_LIMIT_NS);
      $display("pot_deadband_scaler: mismatch");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/pds_pkg.sv
hdl/pot_deadband_scaler.sv
tb/pot_deadband_scaler_test.sv
